>>> design/pmm_pkg.sv
// shared types and constants of the programmable mealy machine
`default_nettype none

package pmm_pkg;

	// number of usable states; loads that name a state at or above this are dropped
	localparam int unsigned NUM_STATES = 16;

	localparam int unsigned STATE_W  = 4;
	localparam int unsigned LETTER_W = 8;
	localparam int unsigned MASK_W   = 16;
	localparam int unsigned TBL_AW   = STATE_W + LETTER_W;
	localparam int unsigned TBL_DEPTH = 1 << TBL_AW;

	typedef enum logic [0:0] {
		ACT_LOAD   = 1'b0,
		ACT_SYMBOL = 1'b1
	} action_t;

	typedef enum logic [0:0] {
		CFG_START_STATE = 1'b0,
		CFG_ACCEPT_MASK = 1'b1
	} cfg_idx_t;

	// one request item
	typedef struct packed {
		logic                action;
		logic [STATE_W-1:0]  from_state;
		logic [STATE_W-1:0]  to_state;
		logic [LETTER_W-1:0] letter;
		logic [LETTER_W-1:0] emit_letter;
		logic                word_end;
	} req_t;

	// one result item
	typedef struct packed {
		logic                moved;
		logic [LETTER_W-1:0] out_letter;
		logic [STATE_W-1:0]  state_now;
		logic                word_done;
		logic                accepted;
	} rsp_t;

	// one transition table entry
	typedef struct packed {
		logic                valid;
		logic [STATE_W-1:0]  dest;
		logic [LETTER_W-1:0] emit;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [TBL_AW-1:0] addr;
	} tbl_rd_t;

	typedef struct packed {
		logic              en;
		logic [TBL_AW-1:0] addr;
		entry_t            data;
	} tbl_wr_t;

endpackage

`default_nettype wire

>>> design/pmm_table.sv
// transition table memory with the clearing sweep after reset
`default_nettype none

module pmm_table (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pmm_pkg::tbl_rd_t rd,
	output pmm_pkg::entry_t       rd_data,
	input  wire pmm_pkg::tbl_wr_t wr,
	output logic                  busy
);
	import pmm_pkg::*;

	entry_t             mem [TBL_DEPTH];
	logic [TBL_AW-1:0]  clr_addr_q;
	logic               clearing_q;

	// sweep every entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == TBL_AW'(TBL_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// read returns the old contents when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	assign busy = clearing_q;

endmodule

`default_nettype wire

>>> design/programmable_mealy_machine_unit.sv
// top level of the programmable mealy machine
//
// usage:
// - request channel (req_valid / req_stall / req): each request either loads one
//   transition (action 0) or feeds one symbol of a word (action 1)
// - result channel (rsp_valid / rsp_stall / rsp): one result per symbol request,
//   none per load request
// - configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
//   is the start state, index 1 the accepting mask; always ready, write only while idle
// - a symbol request is registered in the table read stage, then its result in the output
//   register, from which it is taken while rsp_stall is low
// - when not stalled, one request per cycle is sustained, loads and symbols mixed freely;
//   the next symbol's table address comes straight from the table entry read for the one
//   before, and a load followed by a read of the same entry is forwarded around the memory
// - after reset the transition table is cleared one entry per cycle: req_stall stays
//   high until every entry is cleared, configuration writes are taken meanwhile
// - when the receiver stalls, the finished result waits in the output register; loads
//   still pass, one more symbol is accepted into the table read stage, then req_stall rises
`default_nettype none

module programmable_mealy_machine_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire pmm_pkg::req_t     req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output pmm_pkg::rsp_t          rsp,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire pmm_pkg::cfg_idx_t cfg_index,
	input  wire logic [15:0]       cfg_data
);
	import pmm_pkg::*;

	// configuration registers
	logic [STATE_W-1:0] start_state_q;
	logic [MASK_W-1:0]  accept_mask_q;

	// word walking state as seen after the last symbol that left the read stage
	logic [STATE_W-1:0] cur_state_q;
	logic               stuck_q;
	logic               word_start_q;

	// read stage: request plus the table entry it looked up
	logic               valid_s1;
	req_t               req_s1;
	logic [STATE_W-1:0] base_state_s1;
	logic               base_stuck_s1;
	logic               legal_s1;
	logic               fwd_hit_s1;
	entry_t             fwd_data_s1;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	// table interface
	tbl_rd_t tbl_rd;
	tbl_wr_t tbl_wr;
	entry_t  tbl_rd_data;
	logic    tbl_busy;

	// read stage results
	entry_t             entry_s1;
	logic               sym_s1;
	logic               adv_s1;
	logic [STATE_W-1:0] next_state;
	logic               next_stuck;
	rsp_t               rsp_next;

	// walking state for the request being accepted now
	logic [STATE_W-1:0] ahead_state;
	logic               ahead_stuck;
	logic               ahead_start;
	logic [STATE_W-1:0] base_state;
	logic               base_stuck;
	logic               req_take;

	pmm_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (tbl_rd),
		.rd_data (tbl_rd_data),
		.wr      (tbl_wr),
		.busy    (tbl_busy)
	);

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q <= '0;
			accept_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_STATE: start_state_q <= cfg_data[STATE_W-1:0];
				CFG_ACCEPT_MASK: accept_mask_q <= cfg_data[MASK_W-1:0];
				default:         ;
			endcase
		end
	end

	// entry as it stands after any load that wrote it as this request entered the read stage
	assign entry_s1 = fwd_hit_s1 ? fwd_data_s1 : tbl_rd_data;
	assign sym_s1   = (req_s1.action == ACT_SYMBOL);

	// a load always leaves; a symbol needs room in the output register
	assign adv_s1 = valid_s1 && (!sym_s1 || !rsp_valid_q || !rsp_stall);

	// step the machine for the symbol in the read stage
	always_comb begin
		next_state = base_state_s1;
		next_stuck = base_stuck_s1;
		rsp_next   = '0;
		if (!base_stuck_s1) begin
			if (entry_s1.valid) begin
				next_state          = entry_s1.dest;
				rsp_next.moved      = 1'b1;
				rsp_next.out_letter = entry_s1.emit;
			end else begin
				next_stuck = 1'b1;
			end
		end
		rsp_next.state_now = next_state;
		rsp_next.word_done = req_s1.word_end;
		rsp_next.accepted  = req_s1.word_end & accept_mask_q[next_state];
	end

	// load write back: keep the lower destination on a duplicate letter
	always_comb begin
		tbl_wr      = '0;
		tbl_wr.addr = {req_s1.from_state, req_s1.letter};
		tbl_wr.data = '{valid: 1'b1, dest: req_s1.to_state, emit: req_s1.emit_letter};
		if (valid_s1 && !sym_s1 && legal_s1) begin
			tbl_wr.en = !entry_s1.valid || (req_s1.to_state < entry_s1.dest);
		end
	end

	// walking state the incoming symbol sees: the symbol in the read stage if any
	always_comb begin
		if (valid_s1 && sym_s1) begin
			ahead_state = next_state;
			ahead_stuck = next_stuck;
			ahead_start = req_s1.word_end;
		end else begin
			ahead_state = cur_state_q;
			ahead_stuck = stuck_q;
			ahead_start = word_start_q;
		end
		base_state = ahead_start ? start_state_q : ahead_state;
		base_stuck = ahead_start ? 1'b0 : ahead_stuck;
	end

	// request handshake
	assign req_stall = tbl_busy || (valid_s1 && !adv_s1);
	assign req_take  = req_valid && !req_stall;

	// table read for the incoming request
	always_comb begin
		tbl_rd.en = req_take;
		if (req.action == ACT_SYMBOL) begin
			tbl_rd.addr = {base_state, req.letter};
		end else begin
			tbl_rd.addr = {req.from_state, req.letter};
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1        <= req;
			base_state_s1 <= base_state;
			base_stuck_s1 <= base_stuck;
			legal_s1      <= (32'(req.from_state) < NUM_STATES) &&
			                 (32'(req.to_state) < NUM_STATES);
			fwd_hit_s1    <= tbl_wr.en && (tbl_wr.addr == tbl_rd.addr);
			fwd_data_s1   <= tbl_wr.data;
		end
	end

	// commit the walking state when a symbol leaves the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_state_q  <= '0;
			stuck_q      <= 1'b0;
			word_start_q <= 1'b1;
		end else if (adv_s1 && sym_s1) begin
			cur_state_q  <= next_state;
			stuck_q      <= next_stuck;
			word_start_q <= req_s1.word_end;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1 && sym_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && sym_s1) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
